[design/ihc_pkg.sv]
// Package for the IPv4 receive header check: payload structs, the header
// summary passed from the front end to the back end, verdict and class codes.
// No dependencies.
package ihc_pkg;

  // Default depth of the summary queue between front and back end.
  localparam int unsigned IhcQueueDepth = 2;

  // Reset value of the local address register (10.0.2.15).
  localparam logic [31:0] IhcLocalReset = 32'h0A00020F;

  // Header constants.
  localparam logic [15:0] MinHeaderBytes = 16'd20;
  localparam logic [15:0] FragMask       = 16'h3fff;
  localparam logic [31:0] BroadcastAddr  = 32'hffffffff;
  localparam logic [15:0] SumGood        = 16'hffff;
  localparam logic [15:0] CountMax       = 16'hffff;
  localparam logic [3:0]  IpVersion4     = 4'd4;
  localparam logic [7:0]  ProtoIcmp      = 8'd1;
  localparam logic [7:0]  ProtoUdp       = 8'd17;
  localparam logic [7:0]  ProtoTcp       = 8'd6;

  // Byte offsets of captured header fields.
  localparam logic [15:0] OffTotLenHi = 16'd2;
  localparam logic [15:0] OffTotLenLo = 16'd3;
  localparam logic [15:0] OffFragHi   = 16'd6;
  localparam logic [15:0] OffFragLo   = 16'd7;
  localparam logic [15:0] OffProto    = 16'd9;
  localparam logic [15:0] OffSrcFirst = 16'd12;
  localparam logic [15:0] OffSrcLast  = 16'd15;
  localparam logic [15:0] OffDstFirst = 16'd16;
  localparam logic [15:0] OffDstLast  = 16'd19;

  typedef enum logic [2:0] {
    VerdictAccept   = 3'd0,
    VerdictShort    = 3'd1,
    VerdictVersion  = 3'd2,
    VerdictHdrLen   = 3'd3,
    VerdictTotalLen = 3'd4,
    VerdictChecksum = 3'd5,
    VerdictFragment = 3'd6,
    VerdictNotOurs  = 3'd7
  } verdict_e;

  typedef enum logic [1:0] {
    ClassIcmp  = 2'd0,
    ClassUdp   = 2'd1,
    ClassTcp   = 2'd2,
    ClassOther = 2'd3
  } proto_class_e;

  // One input transfer.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_t;

  // One result transfer.
  typedef struct packed {
    logic [2:0]  verdict;
    logic [1:0]  protocol_class;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [5:0]  header_bytes;
    logic [15:0] payload_bytes;
  } out_t;

  // Everything captured over one packet, handed from front to back end.
  typedef struct packed {
    logic [7:0]  ver_hlen;
    logic [15:0] pkt_len;
    logic [15:0] total_len;
    logic [15:0] hdr_sum;
    logic [15:0] frag;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
  } hdr_sum_t;

  // Queue status seen by the back end and the top level.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

[design/ihc_front.sv]
// Front end of the IPv4 receive header check: accepts one byte per transfer,
// keeps the running header checksum and captures header fields.
// Depends on ihc_pkg.
module ihc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  ihc_pkg::in_t      in_data_i,
  output logic              push_o,
  output ihc_pkg::hdr_sum_t summary_o
);
  import ihc_pkg::*;

  logic [15:0] cnt_q, cnt_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  held_q, held_d;
  logic [7:0]  vihl_q, vihl_d;
  logic [15:0] tl_q, tl_d;
  logic [15:0] frag_q, frag_d;
  logic [7:0]  proto_q, proto_d;
  logic [31:0] src_q, src_d;
  logic [31:0] dst_q, dst_d;

  logic [7:0]  b;
  logic [5:0]  hl;
  logic [15:0] word;
  logic [16:0] sum_wide;
  logic [15:0] sum_fold;

  assign b = in_data_i.data_byte;

  // Ones' complement add of the current header word with end-around carry.
  assign word     = {held_q, b};
  assign sum_wide = {1'b0, sum_q} + {1'b0, word};
  assign sum_fold = sum_wide[16] ? (sum_wide[15:0] + 16'd1) : sum_wide[15:0];

  // Next values of the per-packet state for the byte now offered.
  always_comb begin
    vihl_d  = (cnt_q == 16'd0) ? b : vihl_q;
    hl      = {vihl_d[3:0], 2'b00};
    held_d  = held_q;
    sum_d   = sum_q;
    tl_d    = tl_q;
    frag_d  = frag_q;
    proto_d = proto_q;
    src_d   = src_q;
    dst_d   = dst_q;

    if (cnt_q < {10'd0, hl}) begin
      if (!cnt_q[0]) begin
        held_d = b;
      end else begin
        sum_d = sum_fold;
      end
    end

    if (cnt_q == OffTotLenHi) begin
      tl_d = {b, tl_q[7:0]};
    end else if (cnt_q == OffTotLenLo) begin
      tl_d = {tl_q[15:8], b};
    end else if (cnt_q == OffFragHi) begin
      frag_d = {b, frag_q[7:0]};
    end else if (cnt_q == OffFragLo) begin
      frag_d = {frag_q[15:8], b};
    end else if (cnt_q == OffProto) begin
      proto_d = b;
    end else if (cnt_q >= OffSrcFirst && cnt_q <= OffSrcLast) begin
      src_d = {src_q[23:0], b};
    end else if (cnt_q >= OffDstFirst && cnt_q <= OffDstLast) begin
      dst_d = {dst_q[23:0], b};
    end

    // The byte count saturates rather than wrapping.
    cnt_d = (cnt_q != CountMax) ? (cnt_q + 16'd1) : cnt_q;
  end

  // Summary of the finished packet goes to the queue on the last byte.
  assign push_o = accept_i && in_data_i.last;

  always_comb begin
    summary_o.ver_hlen  = vihl_d;
    summary_o.pkt_len   = cnt_d;
    summary_o.total_len = tl_d;
    summary_o.hdr_sum   = sum_d;
    summary_o.frag      = frag_d;
    summary_o.proto     = proto_d;
    summary_o.src       = src_d;
    summary_o.dst       = dst_d;
  end

  // Per-packet state: updated on every transfer, cleared after the last byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      sum_q   <= '0;
      held_q  <= '0;
      vihl_q  <= '0;
      tl_q    <= '0;
      frag_q  <= '0;
      proto_q <= '0;
      src_q   <= '0;
      dst_q   <= '0;
    end else if (accept_i) begin
      if (in_data_i.last) begin
        cnt_q   <= '0;
        sum_q   <= '0;
        held_q  <= '0;
        vihl_q  <= '0;
        tl_q    <= '0;
        frag_q  <= '0;
        proto_q <= '0;
        src_q   <= '0;
        dst_q   <= '0;
      end else begin
        cnt_q   <= cnt_d;
        sum_q   <= sum_d;
        held_q  <= held_d;
        vihl_q  <= vihl_d;
        tl_q    <= tl_d;
        frag_q  <= frag_d;
        proto_q <= proto_d;
        src_q   <= src_d;
        dst_q   <= dst_d;
      end
    end
  end

endmodule

[design/ihc_queue.sv]
// Short queue of packet summaries between the front and the back end.
// Depends on ihc_pkg.
module ihc_queue #(
  parameter int unsigned Depth = ihc_pkg::IhcQueueDepth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  ihc_pkg::hdr_sum_t     push_data_i,
  input  logic                  pop_i,
  output ihc_pkg::hdr_sum_t     head_o,
  output ihc_pkg::queue_status_t status_o
);
  import ihc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  hdr_sum_t            entries_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;

  assign status_o.full  = (count_q == CntW'(Depth));
  assign status_o.empty = (count_q == '0);
  assign head_o         = entries_q[rd_ptr_q];

  // Pointer and fill count update with explicit wrap.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : (wr_ptr_q + PtrW'(1));
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : (rd_ptr_q + PtrW'(1));
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[design/ihc_back.sv]
// Back end of the IPv4 receive header check: evaluates the checks on a queued
// packet summary and holds the result in an output register.
// Depends on ihc_pkg.
module ihc_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic [31:0]            cfg_data_i,
  input  ihc_pkg::hdr_sum_t      head_i,
  input  ihc_pkg::queue_status_t status_i,
  output logic                   pop_o,
  input  logic                   out_stall_i,
  output logic                   out_valid_o,
  output ihc_pkg::out_t          out_data_o
);
  import ihc_pkg::*;

  logic [31:0] local_q;
  logic        out_valid_q;
  out_t        out_q, res;

  logic [5:0]   hl;
  logic [15:0]  hl_w;
  verdict_e     verdict;
  proto_class_e pclass;

  // Local address register, written by a configuration transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_q <= IhcLocalReset;
    end else if (cfg_valid_i) begin
      local_q <= cfg_data_i;
    end
  end

  // Checks in priority order; the first failing one sets the verdict.
  always_comb begin
    hl   = {head_i.ver_hlen[3:0], 2'b00};
    hl_w = {10'd0, hl};
    if (head_i.pkt_len < MinHeaderBytes) begin
      verdict = VerdictShort;
    end else if (head_i.ver_hlen[7:4] != IpVersion4) begin
      verdict = VerdictVersion;
    end else if (hl_w < MinHeaderBytes || hl_w > head_i.pkt_len) begin
      verdict = VerdictHdrLen;
    end else if (head_i.total_len < hl_w || head_i.total_len > head_i.pkt_len) begin
      verdict = VerdictTotalLen;
    end else if (head_i.hdr_sum != SumGood) begin
      verdict = VerdictChecksum;
    end else if ((head_i.frag & FragMask) != 16'd0) begin
      verdict = VerdictFragment;
    end else if (head_i.dst != local_q && head_i.dst != BroadcastAddr) begin
      verdict = VerdictNotOurs;
    end else begin
      verdict = VerdictAccept;
    end
  end

  // Protocol classification.
  always_comb begin
    case (head_i.proto)
      ProtoIcmp: pclass = ClassIcmp;
      ProtoUdp:  pclass = ClassUdp;
      ProtoTcp:  pclass = ClassTcp;
      default:   pclass = ClassOther;
    endcase
  end

  always_comb begin
    res.verdict             = verdict;
    res.protocol_class      = pclass;
    res.source_address      = head_i.src;
    res.destination_address = head_i.dst;
    res.header_bytes        = hl;
    res.payload_bytes       = (verdict == VerdictAccept) ? (head_i.total_len - hl_w) : 16'd0;
  end

  // Take the next summary whenever the output register is free or draining.
  assign pop_o = !status_i.empty && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[design/ipv4_rx_header_check.sv]
// IPv4 receive header check, top level: front end, summary queue, back end.
// Depends on ihc_pkg, ihc_front, ihc_queue and ihc_back.
//
// Usage:
//   Input channel (in_valid_i, in_stall_o, in_data_i) carries one packet byte
//   per transfer, header first, with last set on the final byte. A byte is
//   taken whenever in_stall_o is low: one byte per clock while not stalled.
//   Output channel (out_valid_o, out_stall_i, out_data_o) carries one result
//   per packet: verdict, protocol class, addresses and lengths.
//   The summary enters the queue of QueueDepth summaries at the edge at which
//   the last byte is transferred; the back end loads its output register from
//   the queue head when that register is free or draining, and the result is
//   offered from that register until the receiver takes it.
//   When the receiver stalls, the result is held and further packets collect
//   in the queue; once the queue is full, in_stall_o is raised until the back
//   end takes an entry. Stall on the input is never raised otherwise.
//   Configuration channel (cfg_valid_i, cfg_ready_o, cfg_data_i) writes the
//   local address; it is always ready and should be used while idle.
//   Reset: the local address returns to 10.0.2.15, all per-packet state is
//   cleared and the queue and output register are emptied.
module ipv4_rx_header_check #(
  parameter int unsigned QueueDepth = ihc_pkg::IhcQueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ihc_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output ihc_pkg::out_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [31:0]   cfg_data_i
);
  import ihc_pkg::*;

  logic          in_accept;
  logic          push;
  logic          pop;
  hdr_sum_t      summary;
  hdr_sum_t      head;
  queue_status_t q_status;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_status.full;
  assign in_accept   = in_valid_i && !in_stall_o;

  // Byte-rate front end.
  ihc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_accept),
    .in_data_i (in_data_i),
    .push_o    (push),
    .summary_o (summary)
  );

  // Queue of finished packet summaries.
  ihc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (summary),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_status)
  );

  // Check evaluation and output register.
  ihc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .head_i      (head),
    .status_i    (q_status),
    .pop_o       (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // The queue is never written while full.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push && q_status.full))
    else $error("summary pushed into a full queue");

  // A last-byte transfer always leaves a summary queued at the next edge.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_data_i.last) |=> !q_status.empty)
    else $error("packet summary lost");

  // An accepted packet always has a header of at least the minimum size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.verdict == VerdictAccept)
      |-> ({10'd0, out_data_o.header_bytes} >= MinHeaderBytes))
    else $error("accepted packet with short header length");

  // The back end only pops when something is queued.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !q_status.empty)
    else $error("pop from an empty queue");

endmodule

[tb/tb_ipv4_rx_header_check.sv]
// Self-checking testbench for ipv4_rx_header_check: random and directed IPv4 packets,
// an in-bench header predictor, random input gaps, random output stalls and local address writes.
// Depends on ihc_pkg and the ipv4_rx_header_check RTL.
module tb_ipv4_rx_header_check;
  timeunit 1ns;
  timeprecision 1ps;

  import ihc_pkg::*;

  // Receiver hold-off length, quiet-cycle limit and settling time after a drain.
  localparam int unsigned RxHoldCycles = 150;
  localparam int unsigned StuckLimit   = 2000;
  localparam int unsigned SettleCycles = 4;

  typedef struct {
    in_t item;
    bit  wait_drain;
  } stim_t;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_t         in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_t        out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i  = '0;

  // Bytes waiting to be offered and packet summaries waiting to come out.
  stim_t tx_bytes[$];
  out_t  expected_summaries[$];

  // Predictor state for the packet currently being received.
  logic [15:0] pkt_bytes     = '0;
  logic [15:0] hdr_sum       = '0;
  logic [7:0]  hdr_hi_byte   = '0;
  logic [7:0]  hdr_ver_ihl   = '0;
  logic [15:0] hdr_total_len = '0;
  logic [15:0] hdr_frag      = '0;
  logic [7:0]  hdr_proto     = '0;
  logic [31:0] hdr_src       = '0;
  logic [31:0] hdr_dst       = '0;
  logic [31:0] local_addr_model = IhcLocalReset;

  // Run control and statistics.
  bit          tx_idling = 1'b0;
  bit          rx_idling = 1'b0;
  int unsigned rx_hold_req = 0;
  int unsigned rx_hold_ack = 0;
  int unsigned rx_stall_left = 0;
  int unsigned tx_gap_left = 0;
  int unsigned stuck_cycles = 0;
  int unsigned mismatch_count = 0;
  int unsigned bytes_queued = 0;
  int unsigned packets_queued = 0;
  int unsigned bytes_accepted = 0;
  int unsigned results_seen = 0;
  int unsigned input_stall_cycles = 0;
  int unsigned cfg_writes = 0;
  int unsigned verdict_hits[8];

  ipv4_rx_header_check dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Prints one line for a mismatch and counts it.
  task automatic report_mismatch(input string msg);
    $display("%0t ns: MISMATCH %s", $time, msg);
    mismatch_count++;
  endtask

  // Idle length: zero when disabled, else mostly zero, often short, rarely long.
  function automatic int unsigned draw_idle(input bit enabled);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 80) return 0;
    if (r < 99) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  // Takes one transferred byte into the predictor; on the final byte the packet
  // summary is worked out, queued as an expectation and the packet state cleared.
  task automatic absorb_header_byte(input in_t beat);
    logic [15:0]  pos;
    logic [15:0]  hdr_len;
    logic [16:0]  wide_sum;
    verdict_e     verdict;
    proto_class_e pclass;
    out_t         summary;
    pos = pkt_bytes;
    if (pos == 16'd0) hdr_ver_ihl = beat.data_byte;
    hdr_len = {10'd0, hdr_ver_ihl[3:0], 2'b00};

    // Ones' complement sum over the header words, carry folded back in.
    if (pos < hdr_len) begin
      if (!pos[0]) begin
        hdr_hi_byte = beat.data_byte;
      end else begin
        wide_sum = {1'b0, hdr_sum} + {1'b0, hdr_hi_byte, beat.data_byte};
        if (wide_sum > 17'h0ffff) wide_sum = wide_sum - 17'h0ffff;
        hdr_sum = wide_sum[15:0];
      end
    end

    // Field capture at fixed header offsets.
    if (pos == OffTotLenHi) hdr_total_len[15:8] = beat.data_byte;
    else if (pos == OffTotLenLo) hdr_total_len[7:0] = beat.data_byte;
    else if (pos == OffFragHi) hdr_frag[15:8] = beat.data_byte;
    else if (pos == OffFragLo) hdr_frag[7:0] = beat.data_byte;
    else if (pos == OffProto) hdr_proto = beat.data_byte;
    else if (pos >= OffSrcFirst && pos <= OffSrcLast) hdr_src = {hdr_src[23:0], beat.data_byte};
    else if (pos >= OffDstFirst && pos <= OffDstLast) hdr_dst = {hdr_dst[23:0], beat.data_byte};

    if (pkt_bytes != CountMax) pkt_bytes++;
    if (!beat.last) return;

    // The first failing check decides the verdict.
    if (pkt_bytes < MinHeaderBytes) verdict = VerdictShort;
    else if (hdr_ver_ihl[7:4] != IpVersion4) verdict = VerdictVersion;
    else if (hdr_len < MinHeaderBytes || hdr_len > pkt_bytes) verdict = VerdictHdrLen;
    else if (hdr_total_len < hdr_len || hdr_total_len > pkt_bytes) verdict = VerdictTotalLen;
    else if (hdr_sum != SumGood) verdict = VerdictChecksum;
    else if ((hdr_frag & FragMask) != 16'd0) verdict = VerdictFragment;
    else if (hdr_dst != local_addr_model && hdr_dst != BroadcastAddr) verdict = VerdictNotOurs;
    else verdict = VerdictAccept;

    case (hdr_proto)
      ProtoIcmp: pclass = ClassIcmp;
      ProtoUdp:  pclass = ClassUdp;
      ProtoTcp:  pclass = ClassTcp;
      default:   pclass = ClassOther;
    endcase

    summary.verdict             = verdict;
    summary.protocol_class      = pclass;
    summary.source_address      = hdr_src;
    summary.destination_address = hdr_dst;
    summary.header_bytes        = hdr_len[5:0];
    summary.payload_bytes       = (verdict == VerdictAccept) ? hdr_total_len - hdr_len : 16'd0;
    expected_summaries.push_back(summary);
    verdict_hits[int'(verdict)]++;

    pkt_bytes     = '0;
    hdr_sum       = '0;
    hdr_hi_byte   = '0;
    hdr_ver_ihl   = '0;
    hdr_total_len = '0;
    hdr_frag      = '0;
    hdr_proto     = '0;
    hdr_src       = '0;
    hdr_dst       = '0;
  endtask

  // Sender: offers queued bytes, holds a stalled byte, inserts random gaps and
  // waits for the output to drain before bytes so marked.
  always @(posedge clk_i or negedge rst_ni) begin
    stim_t nxt;
    logic  offer;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      offer = in_valid_i;
      if (in_valid_i && in_stall_o) input_stall_cycles++;
      if (in_valid_i && !in_stall_o) begin
        absorb_header_byte(in_data_i);
        bytes_accepted++;
        offer = 1'b0;
        tx_gap_left = draw_idle(tx_idling);
      end
      if (!offer) begin
        if (tx_gap_left > 0) begin
          tx_gap_left--;
        end else if (tx_bytes.size() != 0 &&
                     (!tx_bytes[0].wait_drain || expected_summaries.size() == 0)) begin
          nxt = tx_bytes.pop_front();
          in_data_i <= nxt.item;
          offer = 1'b1;
        end
      end
      in_valid_i <= offer;
    end
  end

  // Receiver: checks each result transfer against the oldest expectation and
  // stalls at random, or for one long hold-off when asked.
  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    logic hold;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_summaries.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no packet outstanding",
                                    results_seen));
        end else begin
          want = expected_summaries.pop_front();
          if (out_data_o.verdict !== want.verdict)
            report_mismatch($sformatf("result %0d verdict: got %0d, expected %0d",
                                      results_seen, out_data_o.verdict, want.verdict));
          if (out_data_o.protocol_class !== want.protocol_class)
            report_mismatch($sformatf("result %0d protocol class: got %0d, expected %0d",
                                      results_seen, out_data_o.protocol_class,
                                      want.protocol_class));
          if (out_data_o.source_address !== want.source_address)
            report_mismatch($sformatf("result %0d source: got %h, expected %h",
                                      results_seen, out_data_o.source_address,
                                      want.source_address));
          if (out_data_o.destination_address !== want.destination_address)
            report_mismatch($sformatf("result %0d destination: got %h, expected %h",
                                      results_seen, out_data_o.destination_address,
                                      want.destination_address));
          if (out_data_o.header_bytes !== want.header_bytes)
            report_mismatch($sformatf("result %0d header bytes: got %0d, expected %0d",
                                      results_seen, out_data_o.header_bytes,
                                      want.header_bytes));
          if (out_data_o.payload_bytes !== want.payload_bytes)
            report_mismatch($sformatf("result %0d payload bytes: got %0d, expected %0d",
                                      results_seen, out_data_o.payload_bytes,
                                      want.payload_bytes));
        end
      end
      if (rx_hold_req != rx_hold_ack) begin
        rx_hold_ack   = rx_hold_req;
        rx_stall_left = RxHoldCycles;
      end
      if (rx_stall_left == 0) rx_stall_left = draw_idle(rx_idling);
      hold = (rx_stall_left > 0);
      if (hold) rx_stall_left--;
      out_stall_i <= hold;
    end
  end

  // Watchdog: ends the run when no transfer of any kind happens for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles >= StuckLimit) begin
          $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
                   $time, stuck_cycles, expected_summaries.size());
          $display("ipv4_rx_header_check verification failed");
          $finish;
        end
      end
    end
  end

  task automatic push_byte(input logic [7:0] value, input bit is_last, input bit drain);
    stim_t s;
    s.item.data_byte = value;
    s.item.last      = is_last;
    s.wait_drain     = drain;
    tx_bytes.push_back(s);
    bytes_queued++;
  endtask

  // Builds one packet (valid header checksum if 12 <= header length <= packet length),
  // optionally flips one bit and queues its bytes. Bytes past the fixed header are random.
  task automatic send_datagram(input logic [3:0] version, input logic [3:0] ihl,
                               input logic [15:0] total_len, input int unsigned pkt_len,
                               input logic [15:0] frag, input logic [7:0] proto,
                               input logic [31:0] src, input logic [31:0] dst,
                               input int flip_bit, input bit wait_drain);
    logic [7:0]   pkt[$];
    logic [159:0] base;
    logic [16:0]  wide;
    logic [15:0]  acc;
    int unsigned  hl;
    hl   = ihl * 4;
    base = {version, ihl, 8'($urandom()), total_len, 16'($urandom()), frag,
            8'($urandom()), proto, 16'h0000, src, dst};
    for (int unsigned i = 0; i < pkt_len; i++) begin
      if (i < 20) pkt.push_back(base[159 - 8 * i -: 8]);
      else pkt.push_back(8'($urandom_range(0, 255)));
    end
    // Checksum field set so that the whole header sums to all ones.
    if (hl >= 12 && hl <= pkt_len) begin
      acc = '0;
      for (int unsigned i = 0; i < hl; i += 2) begin
        wide = {1'b0, acc} + {1'b0, pkt[i], pkt[i + 1]};
        if (wide > 17'h0ffff) wide = wide - 17'h0ffff;
        acc = wide[15:0];
      end
      acc = ~acc;
      pkt[10] = acc[15:8];
      pkt[11] = acc[7:0];
    end
    if (flip_bit >= 0) pkt[flip_bit / 8] = pkt[flip_bit / 8] ^ (8'h01 << (flip_bit % 8));
    for (int unsigned i = 0; i < pkt_len; i++)
      push_byte(pkt[i], i == pkt_len - 1, wait_drain && i == 0);
    packets_queued++;
  endtask

  function automatic logic [7:0] pick_protocol();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return ProtoUdp;
    if (r < 55) return ProtoTcp;
    if (r < 75) return ProtoIcmp;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [31:0] pick_destination();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return local_addr_model;
    if (r < 70) return BroadcastAddr;
    return $urandom();
  endfunction

  // Mostly well-formed packets with random content; the rest carry one defect
  // each, or are raw noise.
  task automatic send_random_datagram();
    int unsigned kind, hl, tl, len, n;
    logic [3:0]  ver, ihl;
    logic [15:0] frag;
    int          flip;
    kind = $urandom_range(0, 99);
    if (kind >= 96) begin
      n = $urandom_range(1, 40);
      for (int unsigned i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)), i == n - 1, 1'b0);
      packets_queued++;
      return;
    end
    ver  = IpVersion4;
    ihl  = ($urandom_range(0, 9) < 7) ? 4'd5 : 4'($urandom_range(5, 15));
    hl   = ihl * 4;
    tl   = hl + (($urandom_range(0, 9) < 8) ? $urandom_range(0, 24) : $urandom_range(25, 120));
    len  = tl + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0);
    n    = $urandom_range(0, 99);
    frag = (n < 60) ? 16'h0000 : (n < 85) ? 16'h4000 : 16'($urandom());
    flip = -1;
    if (kind < 70) begin
      // Well-formed.
    end else if (kind < 78) begin
      flip = $urandom_range(0, len * 8 - 1);
    end else if (kind < 84) begin
      len = $urandom_range(1, tl - 1);
    end else if (kind < 88) begin
      ver = 4'($urandom_range(0, 15));
    end else if (kind < 92) begin
      ihl = 4'($urandom_range(0, 4));
    end else begin
      tl = $urandom_range(0, 65535);
    end
    send_datagram(ver, ihl, 16'(tl), len, frag, pick_protocol(), $urandom(),
                  pick_destination(), flip, $urandom_range(0, 19) == 0);
  endtask

  task automatic run_random_phase(input int unsigned min_bytes, input int unsigned min_packets);
    int unsigned start_bytes, start_packets;
    start_bytes   = bytes_queued;
    start_packets = packets_queued;
    while (bytes_queued - start_bytes < min_bytes ||
           packets_queued - start_packets < min_packets)
      send_random_datagram();
  endtask

  task automatic set_idling(input bit tx_on, input bit rx_on);
    @(negedge clk_i);
    tx_idling = tx_on;
    rx_idling = rx_on;
  endtask

  // Waits until every queued byte has gone in and every result has come out,
  // then SettleCycles more for anything still settling inside the block.
  task automatic wait_until_drained();
    @(negedge clk_i);
    while (tx_bytes.size() != 0 || in_valid_i || expected_summaries.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_local_address(input logic [31:0] addr);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= addr;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    local_addr_model = addr;
    cfg_valid_i <= 1'b0;
    cfg_writes++;
    @(negedge clk_i);
  endtask

  // Main sequence: directed packets, then random phases under several local addresses.
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_idling(1'b1, 1'b1);

    // Directed packets against the reset address.
    send_datagram(IpVersion4, 4'd5, 16'd20, 20, 16'h0000, ProtoUdp, 32'h0000_0000,
                  IhcLocalReset, -1, 1'b0);
    send_datagram(IpVersion4, 4'd5, 16'd28, 28, 16'h4000, ProtoTcp, 32'hffff_ffff,
                  BroadcastAddr, -1, 1'b0);
    send_datagram(IpVersion4, 4'd15, 16'd70, 74, 16'h0000, ProtoIcmp, $urandom(),
                  IhcLocalReset, -1, 1'b0);
    send_datagram(IpVersion4, 4'd5, 16'd24, 24, 16'h0000, 8'h00, $urandom(),
                  IhcLocalReset, -1, 1'b0);
    send_datagram(IpVersion4, 4'd5, 16'd20, 20, 16'h8000, 8'hff, $urandom(),
                  IhcLocalReset, -1, 1'b0);
    // Too short: a single byte, then one byte short of a minimum header.
    send_datagram(IpVersion4, 4'd5, 16'd20, 1, 16'h0000, ProtoUdp, $urandom(),
                  IhcLocalReset, -1, 1'b0);
    send_datagram(IpVersion4, 4'd5, 16'd20, 19, 16'h0000, ProtoUdp, $urandom(),
                  IhcLocalReset, -1, 1'b0);
    // Wrong version, header length below minimum and beyond the packet.
    send_datagram(4'd6, 4'd5, 16'd20, 20, 16'h0000, ProtoUdp, $urandom(),
                  IhcLocalReset, -1, 1'b0);
    send_datagram(IpVersion4, 4'd4, 16'd20, 20, 16'h0000, ProtoUdp, $urandom(),
                  IhcLocalReset, -1, 1'b0);
    send_datagram(IpVersion4, 4'd15, 16'd40, 40, 16'h0000, ProtoUdp, $urandom(),
                  IhcLocalReset, -1, 1'b0);
    // Total length below the header and beyond the packet.
    send_datagram(IpVersion4, 4'd5, 16'd19, 20, 16'h0000, ProtoUdp, $urandom(),
                  IhcLocalReset, -1, 1'b0);
    send_datagram(IpVersion4, 4'd5, 16'd21, 20, 16'h0000, ProtoUdp, $urandom(),
                  IhcLocalReset, -1, 1'b0);
    // Corrupted checksum field.
    send_datagram(IpVersion4, 4'd5, 16'd20, 20, 16'h0000, ProtoUdp, $urandom(),
                  IhcLocalReset, 80, 1'b0);
    // More-fragments flag and a non-zero fragment offset.
    send_datagram(IpVersion4, 4'd5, 16'd20, 20, 16'h2000, ProtoUdp, $urandom(),
                  IhcLocalReset, -1, 1'b0);
    send_datagram(IpVersion4, 4'd5, 16'd20, 20, 16'h0001, ProtoUdp, $urandom(),
                  IhcLocalReset, -1, 1'b0);
    // Addressed elsewhere.
    send_datagram(IpVersion4, 4'd5, 16'd20, 20, 16'h0000, ProtoUdp, $urandom(),
                  IhcLocalReset ^ 32'h0000_0100, -1, 1'b1);
    wait_until_drained();

    // Receiver holds off while back-to-back packets fill the block.
    write_local_address($urandom());
    set_idling(1'b0, 1'b1);
    rx_hold_req++;
    for (int i = 0; i < 5; i++)
      send_datagram(IpVersion4, 4'd5, 16'd20, 20, 16'h0000, pick_protocol(), $urandom(),
                    pick_destination(), -1, 1'b0);
    wait_until_drained();
    set_idling(1'b1, 1'b1);
    run_random_phase(40, 2);
    wait_until_drained();

    // All-zero local address.
    write_local_address(32'h0000_0000);
    run_random_phase(40, 2);
    wait_until_drained();

    // All-ones local address, no idling on either side.
    write_local_address(32'hffff_ffff);
    set_idling(1'b0, 1'b0);
    run_random_phase(40, 2);
    wait_until_drained();

    write_local_address($urandom());
    set_idling(1'b1, 1'b1);
    run_random_phase(40, 2);
    wait_until_drained();

    $display("Covered %0d packets (%0d bytes), %0d results, %0d writes, %0d stalled cycles.",
             packets_queued, bytes_accepted, results_seen, cfg_writes, input_stall_cycles);
    $display("Verdict codes 0 to 7 seen: %0d %0d %0d %0d %0d %0d %0d %0d.",
             verdict_hits[0], verdict_hits[1], verdict_hits[2], verdict_hits[3],
             verdict_hits[4], verdict_hits[5], verdict_hits[6], verdict_hits[7]);
    if (mismatch_count == 0) begin
      $display("ipv4_rx_header_check verification clean");
    end else begin
      $display("ipv4_rx_header_check verification failed");
    end
    $finish;
  end

endmodule
